[hw/rtl/lennard_jones_particle_integrator_unit_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the Lennard-Jones particle integrator
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LENNARD_JONES_PARTICLE_INTEGRATOR_UNIT_MACROS_SVH
`define LENNARD_JONES_PARTICLE_INTEGRATOR_UNIT_MACROS_SVH

// A condition that must hold at every clock edge.
`define LJPI_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// A condition that implies another in the same cycle.
`define LJPI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A condition that implies another in the following cycle.
`define LJPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ljpi_pkg.sv]
// ---------------------------------------------------------------------------
// Lennard-Jones particle integrator package
// Types, constants, fixed-point helpers and the control program ROM.
// ---------------------------------------------------------------------------
package ljpi_pkg;

  // Data path widths.
  localparam int unsigned WORD_W  = 48;
  localparam int unsigned FRAC_W  = 32;
  localparam int unsigned HALF_W  = WORD_W / 2;
  localparam int unsigned ACC_W   = 2 * WORD_W;
  localparam int unsigned QUO_W   = WORD_W + FRAC_W;
  localparam int unsigned REM_W   = WORD_W + 2;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned PC_W    = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 47;
  localparam int unsigned DT_W    = 33;
  localparam int unsigned PAR_W   = 47;
  localparam int unsigned FAULT_W = 2;

  // Unit lengths in iterations.
  localparam int unsigned MUL_STEPS  = 4;
  localparam int unsigned DIV_STEPS  = QUO_W;
  localparam int unsigned ROOT_STEPS = WORD_W;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic        [WORD_W-1:0] umag_t;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WELL_DEPTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASS       = 2'd3;

  // Register reset values.
  localparam logic [DT_W-1:0]  DT_RESET   = 33'd4294967;
  localparam logic [PAR_W-1:0] EPS_RESET  = 47'd4294967296;
  localparam logic [PAR_W-1:0] R0_RESET   = 47'd42949672960;
  localparam logic [PAR_W-1:0] MASS_RESET = 47'd4294967296;

  // Item function codes.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // Fault codes.
  localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_ZERO = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_SAT  = 2'd2;

  // Split constants in Q16.32.
  localparam word_t CHI_Q     = 48'sd829716063;
  localparam word_t OM2CHI_Q  = 48'sd2635535170;
  localparam word_t TWELVE_Q  = 48'sd51539607552;
  localparam umag_t WMAX_U    = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WMAX_S    = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WMIN_S    = {1'b1, {(WORD_W-1){1'b0}}};

  // Micro-operations.
  typedef enum logic [3:0] {
    OP_END  = 4'd0,
    OP_MULQ = 4'd1,
    OP_ADDQ = 4'd2,
    OP_SUBQ = 4'd3,
    OP_DIVQ = 4'd4,
    OP_SQX  = 4'd5,
    OP_SQY  = 4'd6,
    OP_SQRT = 4'd7,
    OP_JZR  = 4'd8
  } op_e;

  // Operand sources and destinations.
  typedef enum logic [4:0] {
    SRC_X, SRC_Y, SRC_VX, SRC_VY, SRC_K, SRC_C, SRC_S, SRC_S2, SRC_S6,
    SRC_T, SRC_TMP, SRC_EPS, SRC_R0, SRC_DT, SRC_CHI, SRC_OM2CHI,
    SRC_TWELVE, SRC_NOR, SRC_TWOM
  } src_e;

  typedef struct packed {
    op_e             op;
    src_e            src_a;
    src_e            src_b;
    src_e            dst;
    logic [PC_W-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic  sat;
    word_t val;
  } pack_t;

  // Program entry points.
  localparam logic [PC_W-1:0] PC_END   = 6'd0;
  localparam logic [PC_W-1:0] PC_STEP  = 6'd1;
  localparam logic [PC_W-1:0] PC_LAST  = 6'd57;
  localparam logic [PC_W-1:0] PC_DR2   = 6'd27;
  localparam logic [PC_W-1:0] PC_DR3   = 6'd52;

  // Magnitude of a signed word, exact for the most negative value.
  function automatic umag_t mag(input word_t a);
    return a[WORD_W-1] ? umag_t'(-a) : umag_t'(a);
  endfunction

  // Apply a sign to a magnitude and clip to the signed word range.
  function automatic pack_t sat_pack(input logic neg, input logic [QUO_W-1:0] m);
    logic [QUO_W-1:0] lim;
    umag_t            mw;
    pack_t            r;
    lim = QUO_W'(WMAX_U) + QUO_W'(neg);
    mw  = m[WORD_W-1:0];
    if (m > lim) begin
      r.sat = 1'b1;
      r.val = neg ? WMIN_S : WMAX_S;
    end else begin
      r.sat = 1'b0;
      r.val = neg ? word_t'(~mw + umag_t'(1)) : word_t'(mw);
    end
    return r;
  endfunction

  // Saturating add or subtract.
  function automatic pack_t sat_add(input word_t a, input word_t b, input logic sub);
    logic signed [WORD_W:0] s;
    pack_t                  r;
    s = sub ? ({a[WORD_W-1], a} - {b[WORD_W-1], b}) : ({a[WORD_W-1], a} + {b[WORD_W-1], b});
    if (s[WORD_W] != s[WORD_W-1]) begin
      r.sat = 1'b1;
      r.val = s[WORD_W] ? WMIN_S : WMAX_S;
    end else begin
      r.sat = 1'b0;
      r.val = s[WORD_W-1:0];
    end
    return r;
  endfunction

  function automatic ctl_word_t cw(input op_e op, input src_e a, input src_e b,
                                   input src_e d, input logic [PC_W-1:0] t);
    ctl_word_t w;
    w.op = op; w.src_a = a; w.src_b = b; w.dst = d; w.target = t;
    return w;
  endfunction

  // Control program: kick factor, drift, kick, drift, kick, drift.
  function automatic ctl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctl_word_t w;
    case (pc)
      6'd1:  w = cw(OP_DIVQ, SRC_DT,     SRC_TWOM,   SRC_K,   PC_END);
      // First drift by chi*dt.
      6'd2:  w = cw(OP_MULQ, SRC_CHI,    SRC_DT,     SRC_C,   PC_END);
      6'd3:  w = cw(OP_MULQ, SRC_VX,     SRC_C,      SRC_TMP, PC_END);
      6'd4:  w = cw(OP_ADDQ, SRC_X,      SRC_TMP,    SRC_X,   PC_END);
      6'd5:  w = cw(OP_MULQ, SRC_VY,     SRC_C,      SRC_TMP, PC_END);
      6'd6:  w = cw(OP_ADDQ, SRC_Y,      SRC_TMP,    SRC_Y,   PC_END);
      // First kick.
      6'd7:  w = cw(OP_JZR,  SRC_X,      SRC_Y,      SRC_X,   PC_DR2);
      6'd8:  w = cw(OP_SQX,  SRC_X,      SRC_X,      SRC_X,   PC_END);
      6'd9:  w = cw(OP_SQY,  SRC_Y,      SRC_Y,      SRC_X,   PC_END);
      6'd10: w = cw(OP_SQRT, SRC_X,      SRC_X,      SRC_NOR, PC_END);
      6'd11: w = cw(OP_DIVQ, SRC_R0,     SRC_NOR,    SRC_S,   PC_END);
      6'd12: w = cw(OP_MULQ, SRC_S,      SRC_S,      SRC_S2,  PC_END);
      6'd13: w = cw(OP_MULQ, SRC_S2,     SRC_S2,     SRC_S6,  PC_END);
      6'd14: w = cw(OP_MULQ, SRC_S6,     SRC_S2,     SRC_S6,  PC_END);
      6'd15: w = cw(OP_MULQ, SRC_S6,     SRC_S6,     SRC_S,   PC_END);
      6'd16: w = cw(OP_SUBQ, SRC_S,      SRC_S6,     SRC_T,   PC_END);
      6'd17: w = cw(OP_MULQ, SRC_T,      SRC_EPS,    SRC_T,   PC_END);
      6'd18: w = cw(OP_MULQ, SRC_T,      SRC_TWELVE, SRC_T,   PC_END);
      6'd19: w = cw(OP_DIVQ, SRC_T,      SRC_NOR,    SRC_T,   PC_END);
      6'd20: w = cw(OP_DIVQ, SRC_T,      SRC_NOR,    SRC_T,   PC_END);
      6'd21: w = cw(OP_MULQ, SRC_X,      SRC_T,      SRC_TMP, PC_END);
      6'd22: w = cw(OP_MULQ, SRC_TMP,    SRC_K,      SRC_TMP, PC_END);
      6'd23: w = cw(OP_ADDQ, SRC_VX,     SRC_TMP,    SRC_VX,  PC_END);
      6'd24: w = cw(OP_MULQ, SRC_Y,      SRC_T,      SRC_TMP, PC_END);
      6'd25: w = cw(OP_MULQ, SRC_TMP,    SRC_K,      SRC_TMP, PC_END);
      6'd26: w = cw(OP_ADDQ, SRC_VY,     SRC_TMP,    SRC_VY,  PC_END);
      // Middle drift by (1-2chi)*dt.
      6'd27: w = cw(OP_MULQ, SRC_OM2CHI, SRC_DT,     SRC_C,   PC_END);
      6'd28: w = cw(OP_MULQ, SRC_VX,     SRC_C,      SRC_TMP, PC_END);
      6'd29: w = cw(OP_ADDQ, SRC_X,      SRC_TMP,    SRC_X,   PC_END);
      6'd30: w = cw(OP_MULQ, SRC_VY,     SRC_C,      SRC_TMP, PC_END);
      6'd31: w = cw(OP_ADDQ, SRC_Y,      SRC_TMP,    SRC_Y,   PC_END);
      // Second kick.
      6'd32: w = cw(OP_JZR,  SRC_X,      SRC_Y,      SRC_X,   PC_DR3);
      6'd33: w = cw(OP_SQX,  SRC_X,      SRC_X,      SRC_X,   PC_END);
      6'd34: w = cw(OP_SQY,  SRC_Y,      SRC_Y,      SRC_X,   PC_END);
      6'd35: w = cw(OP_SQRT, SRC_X,      SRC_X,      SRC_NOR, PC_END);
      6'd36: w = cw(OP_DIVQ, SRC_R0,     SRC_NOR,    SRC_S,   PC_END);
      6'd37: w = cw(OP_MULQ, SRC_S,      SRC_S,      SRC_S2,  PC_END);
      6'd38: w = cw(OP_MULQ, SRC_S2,     SRC_S2,     SRC_S6,  PC_END);
      6'd39: w = cw(OP_MULQ, SRC_S6,     SRC_S2,     SRC_S6,  PC_END);
      6'd40: w = cw(OP_MULQ, SRC_S6,     SRC_S6,     SRC_S,   PC_END);
      6'd41: w = cw(OP_SUBQ, SRC_S,      SRC_S6,     SRC_T,   PC_END);
      6'd42: w = cw(OP_MULQ, SRC_T,      SRC_EPS,    SRC_T,   PC_END);
      6'd43: w = cw(OP_MULQ, SRC_T,      SRC_TWELVE, SRC_T,   PC_END);
      6'd44: w = cw(OP_DIVQ, SRC_T,      SRC_NOR,    SRC_T,   PC_END);
      6'd45: w = cw(OP_DIVQ, SRC_T,      SRC_NOR,    SRC_T,   PC_END);
      6'd46: w = cw(OP_MULQ, SRC_X,      SRC_T,      SRC_TMP, PC_END);
      6'd47: w = cw(OP_MULQ, SRC_TMP,    SRC_K,      SRC_TMP, PC_END);
      6'd48: w = cw(OP_ADDQ, SRC_VX,     SRC_TMP,    SRC_VX,  PC_END);
      6'd49: w = cw(OP_MULQ, SRC_Y,      SRC_T,      SRC_TMP, PC_END);
      6'd50: w = cw(OP_MULQ, SRC_TMP,    SRC_K,      SRC_TMP, PC_END);
      6'd51: w = cw(OP_ADDQ, SRC_VY,     SRC_TMP,    SRC_VY,  PC_END);
      // Last drift by chi*dt.
      6'd52: w = cw(OP_MULQ, SRC_CHI,    SRC_DT,     SRC_C,   PC_END);
      6'd53: w = cw(OP_MULQ, SRC_VX,     SRC_C,      SRC_TMP, PC_END);
      6'd54: w = cw(OP_ADDQ, SRC_X,      SRC_TMP,    SRC_X,   PC_END);
      6'd55: w = cw(OP_MULQ, SRC_VY,     SRC_C,      SRC_TMP, PC_END);
      6'd56: w = cw(OP_ADDQ, SRC_Y,      SRC_TMP,    SRC_Y,   PC_END);
      default: w = cw(OP_END, SRC_X,     SRC_X,      SRC_X,   PC_END);
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/ljpi_if.sv]
// ---------------------------------------------------------------------------
// Lennard-Jones particle integrator channel interfaces
// Input, result and configuration channels with valid/ready handshakes.
// ---------------------------------------------------------------------------

// Input item channel.
interface ljpi_in_if;
  logic                  valid;
  logic                  ready;
  logic                  func;
  ljpi_pkg::word_t       init_x;
  ljpi_pkg::word_t       init_y;
  ljpi_pkg::word_t       init_vx;
  ljpi_pkg::word_t       init_vy;

  modport source (output valid, func, init_x, init_y, init_vx, init_vy, input ready);
  modport sink   (input valid, func, init_x, init_y, init_vx, init_vy, output ready);
endinterface

// Result item channel.
interface ljpi_out_if;
  logic                               valid;
  logic                               ready;
  ljpi_pkg::word_t                    pos_x;
  ljpi_pkg::word_t                    pos_y;
  ljpi_pkg::word_t                    vel_x;
  ljpi_pkg::word_t                    vel_y;
  logic [ljpi_pkg::FAULT_W-1:0]       fault;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, fault, input ready);
  modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, fault, output ready);
endinterface

// Configuration write channel.
interface ljpi_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ljpi_pkg::CFG_IDX_W-1:0]      index;
  logic [ljpi_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/lennard_jones_particle_integrator_unit.sv]
// ---------------------------------------------------------------------------
// Lennard-Jones particle integrator
// Microcoded position-Verlet integrator for one 2D particle in Q16.32.
// ---------------------------------------------------------------------------
// The block works on one item at a time. A load transaction passes through
// the execute state, and its result is registered once the output register
// is free; a step transaction runs the control program on the bit-serial
// divider (seven quotients a step), the square-root unit (twice a step) and
// the four-pass 24x24 multiplier. A finished result waits in the output
// register while the next transaction is taken.
// Configuration writes are always accepted and must only be made while idle.

`include "lennard_jones_particle_integrator_unit_macros.svh"

module lennard_jones_particle_integrator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  ljpi_in_if.sink     in_i,
  ljpi_out_if.source  res_o,
  ljpi_cfg_if.sink    cfg_i
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e                        state_q;
  logic [ljpi_pkg::PC_W-1:0]     pc_q;
  logic                          busy_q;
  logic [ljpi_pkg::CNT_W-1:0]    cnt_q;
  logic                          sat_q, zero_q, res_valid_q;

  // Configuration registers.
  logic [ljpi_pkg::DT_W-1:0]     dt_q;
  logic [ljpi_pkg::PAR_W-1:0]    eps_q, r0_q, mass_q;

  // Particle state and temporaries.
  ljpi_pkg::word_t x_q, y_q, vx_q, vy_q;
  ljpi_pkg::word_t k_q, c_q, s_q, s2_q, s6_q, t_q, tmp_q;
  ljpi_pkg::umag_t nor_q;
  logic [ljpi_pkg::ACC_W-1:0] r2_q;

  // Multiplier unit.
  ljpi_pkg::umag_t             ma_q, mb_q;
  logic                        mneg_q;
  logic [ljpi_pkg::ACC_W-1:0]  acc_q;

  // Divider unit.
  logic [ljpi_pkg::QUO_W-1:0]  dn_q;
  ljpi_pkg::umag_t             dd_q, drem_q;
  logic                        dneg_q;

  // Square-root unit.
  logic [ljpi_pkg::ACC_W-1:0]  rad_q;
  ljpi_pkg::umag_t             root_q;
  logic [ljpi_pkg::REM_W-1:0]  srem_q;

  ljpi_pkg::ctl_word_t         cw;
  ljpi_pkg::word_t             opa, opb;
  ljpi_pkg::umag_t             twom, divisor;
  logic [ljpi_pkg::CNT_W-1:0]  unit_last;
  logic                        multi_op, done, stepping, launch;
  logic                        in_fire, end_fire, wr_en;
  ljpi_pkg::pack_t             mul_res, div_res, add_res, wr_res;
  logic [ljpi_pkg::HALF_W-1:0] pa, pb;
  logic [2*ljpi_pkg::HALF_W-1:0] pp;
  logic [ljpi_pkg::ACC_W-1:0]  pp_sh;
  logic [ljpi_pkg::WORD_W:0]   dsh;
  logic [ljpi_pkg::REM_W+1:0]  rsh, trial;

  // Operand selection from the named registers and constants.
  function automatic ljpi_pkg::word_t sel(input ljpi_pkg::src_e s);
    case (s)
      ljpi_pkg::SRC_X:      return x_q;
      ljpi_pkg::SRC_Y:      return y_q;
      ljpi_pkg::SRC_VX:     return vx_q;
      ljpi_pkg::SRC_VY:     return vy_q;
      ljpi_pkg::SRC_K:      return k_q;
      ljpi_pkg::SRC_C:      return c_q;
      ljpi_pkg::SRC_S:      return s_q;
      ljpi_pkg::SRC_S2:     return s2_q;
      ljpi_pkg::SRC_S6:     return s6_q;
      ljpi_pkg::SRC_T:      return t_q;
      ljpi_pkg::SRC_TMP:    return tmp_q;
      ljpi_pkg::SRC_EPS:    return ljpi_pkg::word_t'(eps_q);
      ljpi_pkg::SRC_R0:     return ljpi_pkg::word_t'(r0_q);
      ljpi_pkg::SRC_DT:     return ljpi_pkg::word_t'(dt_q);
      ljpi_pkg::SRC_CHI:    return ljpi_pkg::CHI_Q;
      ljpi_pkg::SRC_OM2CHI: return ljpi_pkg::OM2CHI_Q;
      ljpi_pkg::SRC_TWELVE: return ljpi_pkg::TWELVE_Q;
      default:              return '0;
    endcase
  endfunction

  // Control word fetch and operand routing.
  assign cw      = ljpi_pkg::ucode_rom(pc_q);

  always_comb begin
    opa = sel(cw.src_a);
    opb = sel(cw.src_b);
  end

  assign twom    = (mass_q == '0) ? ljpi_pkg::umag_t'(2)
                                  : ljpi_pkg::umag_t'({mass_q, 1'b0});
  assign divisor = (cw.src_b == ljpi_pkg::SRC_TWOM) ? twom : nor_q;

  // Iteration count of the unit the current word uses.
  always_comb begin
    multi_op  = 1'b1;
    unit_last = ljpi_pkg::CNT_W'(ljpi_pkg::MUL_STEPS);
    case (cw.op)
      ljpi_pkg::OP_MULQ, ljpi_pkg::OP_SQX, ljpi_pkg::OP_SQY: begin
        unit_last = ljpi_pkg::CNT_W'(ljpi_pkg::MUL_STEPS);
      end
      ljpi_pkg::OP_DIVQ: begin
        unit_last = ljpi_pkg::CNT_W'(ljpi_pkg::DIV_STEPS);
      end
      ljpi_pkg::OP_SQRT: begin
        unit_last = ljpi_pkg::CNT_W'(ljpi_pkg::ROOT_STEPS);
      end
      default: begin
        multi_op = 1'b0;
      end
    endcase
  end

  assign in_fire  = in_i.valid && in_i.ready;
  assign done     = busy_q && (cnt_q == unit_last);
  assign stepping = busy_q && !done;
  assign launch   = (state_q == ST_EXEC) && multi_op && !busy_q;
  assign end_fire = (state_q == ST_EXEC) && (cw.op == ljpi_pkg::OP_END) &&
                    (!res_valid_q || res_o.ready);

  // Multiplier partial product for the current pass.
  assign pa = cnt_q[1] ? ma_q[ljpi_pkg::WORD_W-1:ljpi_pkg::HALF_W]
                       : ma_q[ljpi_pkg::HALF_W-1:0];
  assign pb = cnt_q[0] ? mb_q[ljpi_pkg::WORD_W-1:ljpi_pkg::HALF_W]
                       : mb_q[ljpi_pkg::HALF_W-1:0];
  assign pp = pa * pb;

  always_comb begin
    case (cnt_q[1:0])
      2'b00:        pp_sh = ljpi_pkg::ACC_W'(pp);
      2'b01, 2'b10: pp_sh = ljpi_pkg::ACC_W'(pp) << ljpi_pkg::HALF_W;
      default:      pp_sh = ljpi_pkg::ACC_W'(pp) << ljpi_pkg::WORD_W;
    endcase
  end

  // Divider and square-root trial values.
  assign dsh   = {drem_q, dn_q[ljpi_pkg::QUO_W-1]};
  assign rsh   = {srem_q, rad_q[ljpi_pkg::ACC_W-1 -: 2]};
  assign trial = (ljpi_pkg::REM_W+2)'({root_q, 2'b01});

  // Result formatting of the units and the adder.
  assign mul_res = ljpi_pkg::sat_pack(mneg_q,
                     ljpi_pkg::QUO_W'(acc_q[ljpi_pkg::ACC_W-1:ljpi_pkg::FRAC_W]));
  assign div_res = ljpi_pkg::sat_pack(dneg_q, dn_q);
  assign add_res = ljpi_pkg::sat_add(opa, opb, cw.op == ljpi_pkg::OP_SUBQ);

  always_comb begin
    wr_en  = 1'b0;
    wr_res = add_res;
    if (state_q == ST_EXEC) begin
      case (cw.op)
        ljpi_pkg::OP_ADDQ, ljpi_pkg::OP_SUBQ: wr_en = 1'b1;
        ljpi_pkg::OP_MULQ: begin
          wr_en  = done;
          wr_res = mul_res;
        end
        ljpi_pkg::OP_DIVQ: begin
          wr_en  = done;
          wr_res = div_res;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = res_valid_q;

  // Sequencer, flags, configuration and particle state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= ljpi_pkg::PC_END;
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      sat_q       <= 1'b0;
      zero_q      <= 1'b0;
      res_valid_q <= 1'b0;
      dt_q        <= ljpi_pkg::DT_RESET;
      eps_q       <= ljpi_pkg::EPS_RESET;
      r0_q        <= ljpi_pkg::R0_RESET;
      mass_q      <= ljpi_pkg::MASS_RESET;
      x_q         <= '0;
      y_q         <= '0;
      vx_q        <= '0;
      vy_q        <= '0;
    end else begin
      // Configuration writes.
      if (cfg_i.valid) begin
        case (cfg_i.index)
          ljpi_pkg::CFG_TIME_STEP:  dt_q   <= cfg_i.data[ljpi_pkg::DT_W-1:0];
          ljpi_pkg::CFG_WELL_DEPTH: eps_q  <= cfg_i.data;
          ljpi_pkg::CFG_RADIUS:     r0_q   <= cfg_i.data;
          ljpi_pkg::CFG_MASS:       mass_q <= cfg_i.data;
          default: ;
        endcase
      end

      // Result register hand-off.
      res_valid_q <= end_fire || (res_valid_q && !res_o.ready);

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_EXEC;
            busy_q  <= 1'b0;
            cnt_q   <= '0;
            sat_q   <= 1'b0;
            zero_q  <= 1'b0;
            if (in_i.func == ljpi_pkg::FUNC_LOAD) begin
              x_q  <= in_i.init_x;
              y_q  <= in_i.init_y;
              vx_q <= in_i.init_vx;
              vy_q <= in_i.init_vy;
              pc_q <= ljpi_pkg::PC_END;
            end else begin
              pc_q <= ljpi_pkg::PC_STEP;
            end
          end
        end
        ST_EXEC: begin
          // State register writes and the saturation flag.
          if (wr_en) begin
            sat_q <= sat_q | wr_res.sat;
            case (cw.dst)
              ljpi_pkg::SRC_X:  x_q  <= wr_res.val;
              ljpi_pkg::SRC_Y:  y_q  <= wr_res.val;
              ljpi_pkg::SRC_VX: vx_q <= wr_res.val;
              ljpi_pkg::SRC_VY: vy_q <= wr_res.val;
              default: ;
            endcase
          end
          // Program flow.
          if (cw.op == ljpi_pkg::OP_END) begin
            if (end_fire) begin
              state_q <= ST_IDLE;
            end
          end else if (cw.op == ljpi_pkg::OP_JZR) begin
            if (x_q == '0 && y_q == '0) begin
              zero_q <= 1'b1;
              pc_q   <= cw.target;
            end else begin
              pc_q <= pc_q + 1'b1;
            end
          end else if (multi_op) begin
            if (!busy_q) begin
              busy_q <= 1'b1;
              cnt_q  <= '0;
            end else if (done) begin
              busy_q <= 1'b0;
              pc_q   <= pc_q + 1'b1;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end else begin
            pc_q <= pc_q + 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Arithmetic units, temporaries and the result payload.
  always_ff @(posedge clk_i) begin
    if (launch) begin
      case (cw.op)
        ljpi_pkg::OP_MULQ: begin
          ma_q   <= ljpi_pkg::mag(opa);
          mb_q   <= ljpi_pkg::mag(opb);
          mneg_q <= opa[ljpi_pkg::WORD_W-1] ^ opb[ljpi_pkg::WORD_W-1];
          acc_q  <= '0;
        end
        ljpi_pkg::OP_SQX: begin
          ma_q  <= ljpi_pkg::mag(x_q);
          mb_q  <= ljpi_pkg::mag(x_q);
          acc_q <= '0;
        end
        ljpi_pkg::OP_SQY: begin
          ma_q  <= ljpi_pkg::mag(y_q);
          mb_q  <= ljpi_pkg::mag(y_q);
          acc_q <= '0;
        end
        ljpi_pkg::OP_DIVQ: begin
          dn_q   <= {ljpi_pkg::mag(opa), ljpi_pkg::FRAC_W'(0)};
          dd_q   <= divisor;
          drem_q <= '0;
          dneg_q <= opa[ljpi_pkg::WORD_W-1];
        end
        ljpi_pkg::OP_SQRT: begin
          rad_q  <= r2_q;
          root_q <= '0;
          srem_q <= '0;
        end
        default: ;
      endcase
    end else if (stepping) begin
      case (cw.op)
        ljpi_pkg::OP_MULQ, ljpi_pkg::OP_SQX, ljpi_pkg::OP_SQY: begin
          acc_q <= acc_q + pp_sh;
        end
        ljpi_pkg::OP_DIVQ: begin
          // One restoring division step per cycle.
          if (dsh >= {1'b0, dd_q}) begin
            drem_q <= ljpi_pkg::WORD_W'(dsh - {1'b0, dd_q});
            dn_q   <= {dn_q[ljpi_pkg::QUO_W-2:0], 1'b1};
          end else begin
            drem_q <= dsh[ljpi_pkg::WORD_W-1:0];
            dn_q   <= {dn_q[ljpi_pkg::QUO_W-2:0], 1'b0};
          end
        end
        ljpi_pkg::OP_SQRT: begin
          // One root bit per cycle from two radicand bits.
          rad_q <= rad_q << 2;
          if (rsh >= trial) begin
            srem_q <= ljpi_pkg::REM_W'(rsh - trial);
            root_q <= {root_q[ljpi_pkg::WORD_W-2:0], 1'b1};
          end else begin
            srem_q <= rsh[ljpi_pkg::REM_W-1:0];
            root_q <= {root_q[ljpi_pkg::WORD_W-2:0], 1'b0};
          end
        end
        default: ;
      endcase
    end

    // Unit results that are not particle state.
    if (state_q == ST_EXEC && done) begin
      case (cw.op)
        ljpi_pkg::OP_SQX:  r2_q  <= acc_q;
        ljpi_pkg::OP_SQY:  r2_q  <= r2_q + acc_q;
        ljpi_pkg::OP_SQRT: nor_q <= root_q;
        default: ;
      endcase
    end

    // Temporary register writes.
    if (wr_en) begin
      case (cw.dst)
        ljpi_pkg::SRC_K:   k_q   <= wr_res.val;
        ljpi_pkg::SRC_C:   c_q   <= wr_res.val;
        ljpi_pkg::SRC_S:   s_q   <= wr_res.val;
        ljpi_pkg::SRC_S2:  s2_q  <= wr_res.val;
        ljpi_pkg::SRC_S6:  s6_q  <= wr_res.val;
        ljpi_pkg::SRC_T:   t_q   <= wr_res.val;
        ljpi_pkg::SRC_TMP: tmp_q <= wr_res.val;
        default: ;
      endcase
    end

    // Result payload.
    if (end_fire) begin
      res_o.pos_x <= x_q;
      res_o.pos_y <= y_q;
      res_o.vel_x <= vx_q;
      res_o.vel_y <= vy_q;
      res_o.fault <= sat_q  ? ljpi_pkg::FAULT_SAT :
                     zero_q ? ljpi_pkg::FAULT_ZERO : ljpi_pkg::FAULT_NONE;
    end
  end

  // A unit only runs while a program executes.
  `LJPI_ASSERT_IMPL(a_busy_exec, busy_q, state_q == ST_EXEC, "unit busy outside execution")
  // The program counter stays inside the control program.
  `LJPI_ASSERT_IMPL(a_pc_range, state_q == ST_EXEC, pc_q <= ljpi_pkg::PC_LAST,
                    "program counter left the control program")
  // An accepted transaction always starts the sequencer.
  `LJPI_ASSERT_NEXT(a_start, in_fire, state_q == ST_EXEC && !busy_q,
                    "sequencer did not start after acceptance")
  // A unit never counts past its last iteration.
  `LJPI_ASSERT_IMPL(a_cnt_bound, busy_q, cnt_q <= unit_last, "unit iteration count overran")

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// Testbench for the Lennard-Jones particle integrator
// Feeds load and step transactions in bursts, predicts each result with a
// fixed-point model of the split integrator and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam longint WMAX_L = 64'sd140737488355327;
  localparam longint WMIN_L = -64'sd140737488355328;
  localparam logic [63:0] CHI_C = 64'd829716063;
  localparam logic [63:0] OM2CHI_C = 64'd2635535170;
  localparam logic [63:0] ONE_Q = 64'd4294967296;

  typedef struct {
    logic   func;
    longint x, y, vx, vy;
  } particle_item_t;

  typedef struct {
    longint                       x, y, vx, vy;
    logic [ljpi_pkg::FAULT_W-1:0] fault;
  } particle_state_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ljpi_in_if  in_ch ();
  ljpi_out_if res_ch ();
  ljpi_cfg_if cfg_ch ();

  lennard_jones_particle_integrator_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state and configuration.
  logic [63:0] dt_reg, eps_reg, r0_reg, mass_reg;
  longint      px, py, pvx, pvy;
  bit          clipped, at_origin;

  particle_item_t  pending_q[$];
  particle_state_t expected_q[$];
  int              mismatches = 0;
  int              results_seen = 0;

  function automatic logic [63:0] magnitude(input longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  // Sign and clip a magnitude into the word range.
  function automatic longint clip_signed(input bit neg, input logic [127:0] m);
    logic [127:0] lim;
    lim = 128'(WMAX_L) + 128'(neg);
    if (m > lim) begin
      clipped = 1'b1;
      return neg ? WMIN_L : WMAX_L;
    end
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint mul_mag(input logic [63:0] ma, input logic [63:0] mb,
                                     input bit neg);
    logic [127:0] p;
    p = {64'd0, ma} * {64'd0, mb};
    return clip_signed(neg, p >> 32);
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    return mul_mag(magnitude(a), magnitude(b), (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_div(input longint a, input logic [63:0] d);
    logic [127:0] n;
    n = {64'd0, magnitude(a)} << 32;
    return clip_signed(a < 0, n / {64'd0, d});
  endfunction

  function automatic longint fx_add(input longint a, input longint b);
    if (b > 0 && a > WMAX_L - b) begin
      clipped = 1'b1;
      return WMAX_L;
    end
    if (b < 0 && a < WMIN_L - b) begin
      clipped = 1'b1;
      return WMIN_L;
    end
    return a + b;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
    logic [63:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  // Central force at the current position, scaled by the kick factor.
  function automatic void apply_kick(input longint k);
    logic [127:0] r2;
    logic [63:0]  nrm;
    longint       s, s2, s6, s12, t, g;
    if (px == 0 && py == 0) begin
      at_origin = 1'b1;
      return;
    end
    r2 = {64'd0, magnitude(px)} * {64'd0, magnitude(px)}
       + {64'd0, magnitude(py)} * {64'd0, magnitude(py)};
    nrm = floor_sqrt(r2);
    s   = fx_div(longint'(r0_reg), nrm);
    s2  = fx_mul(s, s);
    s6  = fx_mul(fx_mul(s2, s2), s2);
    s12 = fx_mul(s6, s6);
    t   = fx_mul(fx_mul(fx_add(s12, -s6), longint'(eps_reg)), longint'(64'd12 << 32));
    g   = fx_div(fx_div(t, nrm), nrm);
    pvx = fx_add(pvx, fx_mul(fx_mul(px, g), k));
    pvy = fx_add(pvy, fx_mul(fx_mul(py, g), k));
  endfunction

  function automatic void apply_drift(input logic [63:0] coef);
    logic [127:0] p;
    logic [63:0]  c;
    p   = {64'd0, coef} * {64'd0, dt_reg};
    c   = p[95:32];
    px  = fx_add(px, mul_mag(magnitude(pvx), c, pvx < 0));
    py  = fx_add(py, mul_mag(magnitude(pvy), c, pvy < 0));
  endfunction

  // Works out the state that one accepted transaction leaves behind.
  function automatic particle_state_t integrate_item(input particle_item_t it);
    particle_state_t r;
    logic [63:0]     twom;
    longint          k;
    clipped   = 1'b0;
    at_origin = 1'b0;
    r.fault   = ljpi_pkg::FAULT_NONE;
    if (it.func == ljpi_pkg::FUNC_LOAD) begin
      px = it.x; py = it.y; pvx = it.vx; pvy = it.vy;
    end else begin
      twom = (mass_reg == 0) ? 64'd2 : mass_reg << 1;
      k = fx_div(longint'(dt_reg), twom);
      apply_drift(CHI_C);
      apply_kick(k);
      apply_drift(OM2CHI_C);
      apply_kick(k);
      apply_drift(CHI_C);
      if (clipped) r.fault = ljpi_pkg::FAULT_SAT;
      else if (at_origin) r.fault = ljpi_pkg::FAULT_ZERO;
    end
    r.x = px; r.y = py; r.vx = pvx; r.vy = pvy;
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int  burst_left = 0;
  int  gap_left = 0;
  bit  item_taken = 1'b0;

  always @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      expected_q.push_back(integrate_item(pending_q[0]));
      void'(pending_q.pop_front());
      item_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && !item_taken) begin
        // Hold the offered item until it is accepted.
      end else if (gap_left > 0 || pending_q.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        if (burst_left == 0 && $urandom_range(0, 2) != 0) gap_left = $urandom_range(1, 25);
        in_ch.valid   <= 1'b1;
        in_ch.func    <= pending_q[0].func;
        in_ch.init_x  <= ljpi_pkg::word_t'(pending_q[0].x);
        in_ch.init_y  <= ljpi_pkg::word_t'(pending_q[0].y);
        in_ch.init_vx <= ljpi_pkg::word_t'(pending_q[0].vx);
        in_ch.init_vy <= ljpi_pkg::word_t'(pending_q[0].vy);
      end
      item_taken = 1'b0;
    end
  end

  // Receiver: stalls on windows of random mode, with one long hold-off.
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  int window_left = 0;
  int ready_mode = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (window_left == 0) begin
        window_left = $urandom_range(16, 200);
        ready_mode  = $urandom_range(0, 2);
      end
      window_left--;
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 200) begin
        long_hold_done = 1'b1;
        hold_left = 4000;
        res_ch.ready <= 1'b0;
      end else begin
        case (ready_mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= $urandom_range(0, 1);
          default: res_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    particle_state_t e;
    bit              bad;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no transaction outstanding");
      end else begin
        e = expected_q.pop_front();
        bad = (res_ch.pos_x !== ljpi_pkg::word_t'(e.x))
           || (res_ch.pos_y !== ljpi_pkg::word_t'(e.y))
           || (res_ch.vel_x !== ljpi_pkg::word_t'(e.vx))
           || (res_ch.vel_y !== ljpi_pkg::word_t'(e.vy))
           || (res_ch.fault !== e.fault);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h vx=%h vy=%h f=%0d got x=%h y=%h vx=%h vy=%h f=%0d",
                     ljpi_pkg::word_t'(e.x), ljpi_pkg::word_t'(e.y),
                     ljpi_pkg::word_t'(e.vx), ljpi_pkg::word_t'(e.vy), e.fault,
                     res_ch.pos_x, res_ch.pos_y, res_ch.vel_x, res_ch.vel_y, res_ch.fault);
        end
      end
    end
  end

  function automatic longint rand_word();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return longint'(ljpi_pkg::word_t'(v[47:0]));
  endfunction

  // A value of modest size, in units of whole numbers with a random fraction.
  function automatic longint rand_near(input int lo, input int hi);
    longint v;
    v = (longint'($urandom_range(lo, hi)) << 32) | longint'($urandom);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic particle_item_t make_item(input logic f, input longint x, input longint y,
                                               input longint vx, input longint vy);
    particle_item_t it;
    it.func = f; it.x = x; it.y = y; it.vx = vx; it.vy = vy;
    return it;
  endfunction

  function automatic particle_item_t rand_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10)
      return make_item(ljpi_pkg::FUNC_LOAD, rand_near(2, 20), rand_near(0, 20),
                       rand_near(0, 3), rand_near(0, 3));
    if (sel < 14)
      return make_item(ljpi_pkg::FUNC_LOAD, rand_word(), rand_word(), rand_word(),
                       rand_word());
    if (sel < 16)
      return make_item(ljpi_pkg::FUNC_LOAD, 0, 0, rand_near(0, 2), rand_near(0, 2));
    return make_item(ljpi_pkg::FUNC_STEP, rand_word(), rand_word(), rand_word(), rand_word());
  endfunction

  task automatic write_reg(input logic [ljpi_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val[ljpi_pkg::CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      ljpi_pkg::CFG_TIME_STEP:  dt_reg   = val & 64'h1_FFFF_FFFF;
      ljpi_pkg::CFG_WELL_DEPTH: eps_reg  = val & 64'h7FFF_FFFF_FFFF;
      ljpi_pkg::CFG_RADIUS:     r0_reg   = val & 64'h7FFF_FFFF_FFFF;
      default:                  mass_reg = val & 64'h7FFF_FFFF_FFFF;
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && expected_q.size() == 0);
    repeat (5) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pick(input logic [63:0] a, input logic [63:0] b,
                                       input logic [63:0] c, input logic [63:0] d);
    case ($urandom_range(0, 3))
      0: return a;
      1: return b;
      2: return c;
      default: return d;
    endcase
  endfunction

  // Stimulus: directed checks, then configuration phases with random items.
  initial begin
    in_ch.valid = 1'b0; in_ch.func = ljpi_pkg::FUNC_LOAD;
    in_ch.init_x = '0; in_ch.init_y = '0; in_ch.init_vx = '0; in_ch.init_vy = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = ljpi_pkg::CFG_TIME_STEP; cfg_ch.data = '0;
    dt_reg = 64'(ljpi_pkg::DT_RESET); eps_reg = 64'(ljpi_pkg::EPS_RESET);
    r0_reg = 64'(ljpi_pkg::R0_RESET); mass_reg = 64'(ljpi_pkg::MASS_RESET);
    px = 0; py = 0; pvx = 0; pvy = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero distance from reset, extremes of every field, and a particle near
    // the well that moves without clipping.
    pending_q.push_back(make_item(ljpi_pkg::FUNC_STEP, 0, 0, 0, 0));
    pending_q.push_back(make_item(ljpi_pkg::FUNC_LOAD, WMAX_L, WMIN_L, WMAX_L, WMIN_L));
    pending_q.push_back(make_item(ljpi_pkg::FUNC_STEP, 0, 0, 0, 0));
    pending_q.push_back(make_item(ljpi_pkg::FUNC_LOAD, WMIN_L, WMAX_L, WMIN_L, WMAX_L));
    pending_q.push_back(make_item(ljpi_pkg::FUNC_STEP, -1, -1, -1, -1));
    pending_q.push_back(make_item(ljpi_pkg::FUNC_LOAD, 1, 0, 0, 0));
    pending_q.push_back(make_item(ljpi_pkg::FUNC_STEP, 0, 0, 0, 0));
    pending_q.push_back(make_item(ljpi_pkg::FUNC_LOAD, -1, -1, -1, -1));
    pending_q.push_back(make_item(ljpi_pkg::FUNC_STEP, 0, 0, 0, 0));
    pending_q.push_back(make_item(ljpi_pkg::FUNC_LOAD, 0, 0, longint'(ONE_Q),
                                  -longint'(ONE_Q)));
    pending_q.push_back(make_item(ljpi_pkg::FUNC_STEP, 0, 0, 0, 0));
    pending_q.push_back(make_item(ljpi_pkg::FUNC_LOAD, 10 * longint'(ONE_Q), 0, 0,
                                  longint'(ONE_Q)));
    repeat (4) pending_q.push_back(make_item(ljpi_pkg::FUNC_STEP, 0, 0, 0, 0));
    pending_q.push_back(make_item(ljpi_pkg::FUNC_LOAD, 11 * longint'(ONE_Q),
                                  -3 * longint'(ONE_Q), -2 * longint'(ONE_Q), 0));
    repeat (3) pending_q.push_back(make_item(ljpi_pkg::FUNC_STEP, 0, 0, 0, 0));
    repeat (150) pending_q.push_back(rand_item());
    // The sender pauses here until every result has come back.
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin
          write_reg(ljpi_pkg::CFG_TIME_STEP, 64'h1_0000_0000);
          write_reg(ljpi_pkg::CFG_WELL_DEPTH, 64'h7FFF_FFFF_FFFF);
          write_reg(ljpi_pkg::CFG_RADIUS, 64'h7FFF_FFFF_FFFF);
          write_reg(ljpi_pkg::CFG_MASS, 64'd1);
        end
        1: begin
          write_reg(ljpi_pkg::CFG_TIME_STEP, 64'd1);
          write_reg(ljpi_pkg::CFG_WELL_DEPTH, 64'd0);
          write_reg(ljpi_pkg::CFG_RADIUS, 64'd1);
          write_reg(ljpi_pkg::CFG_MASS, 64'h7FFF_FFFF_FFFF);
        end
        2: begin
          write_reg(ljpi_pkg::CFG_TIME_STEP, 64'd42949673);
          write_reg(ljpi_pkg::CFG_WELL_DEPTH, ONE_Q);
          write_reg(ljpi_pkg::CFG_RADIUS, 10 * ONE_Q);
          write_reg(ljpi_pkg::CFG_MASS, 64'd0);
        end
        default: begin
          write_reg(ljpi_pkg::CFG_TIME_STEP,
                    pick(64'd1, 64'h1_0000_0000, 64'd4294967, 64'd42949673));
          write_reg(ljpi_pkg::CFG_WELL_DEPTH,
                    pick(64'd0, 64'h7FFF_FFFF_FFFF, ONE_Q, ONE_Q >> 3));
          write_reg(ljpi_pkg::CFG_RADIUS,
                    pick(64'd1, 64'h7FFF_FFFF_FFFF, 10 * ONE_Q, ONE_Q));
          write_reg(ljpi_pkg::CFG_MASS,
                    pick(64'd1, 64'h7FFF_FFFF_FFFF, ONE_Q, ONE_Q << 2));
        end
      endcase
      repeat (150) pending_q.push_back(rand_item());
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #200ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
